[rtl/u16u8_pkg.sv]
// u16u8_pkg: types, constants and queue depth default for the utf-16 to utf-8 transcoder
// depends on nothing; used by every other file in rtl
package u16u8_pkg;

	localparam int CP_W = 21;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	// one request's worth of characters, at most two
	typedef struct packed {
		logic [CP_W-1:0] cp0;
		logic [CP_W-1:0] cp1;
		logic            two;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic half_valid;
		logic high_valid;
	} front_stat_t;

endpackage

[rtl/u16u8_front.sv]
// u16u8_front: accepts input bytes, pairs them into code units and surrogate pairs
// produces one run of up to two code points per request; uses u16u8_pkg
module u16u8_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_data,
	input  logic                  accept,
	input  logic [7:0]            in_byte,
	input  logic                  end_of_stream,
	output logic                  push,
	output u16u8_pkg::run_t       run,
	output u16u8_pkg::front_stat_t stat
);

	logic                        big_endian_q;
	logic [7:0]                  low_half_q;
	logic                        half_valid_q;
	logic [9:0]                  held_high_q;
	logic                        high_valid_q;

	logic [7:0]                  low_half_n;
	logic                        half_valid_n;
	logic [9:0]                  held_high_n;
	logic                        high_valid_n;

	logic [15:0]                 unit;
	logic                        is_high;
	logic                        is_low;
	logic [10:0]                 supp_hi;
	logic [u16u8_pkg::CP_W-1:0]  supp_cp;
	logic                        pre_v;
	logic                        main_v;
	logic [u16u8_pkg::CP_W-1:0]  main_cp;
	logic                        eos_v;

	assign unit    = big_endian_q ? {low_half_q, in_byte} : {in_byte, low_half_q};
	assign is_high = (unit[15:10] == 6'b110110);
	assign is_low  = (unit[15:10] == 6'b110111);
	assign supp_hi = {1'b0, held_high_q} + 11'd64;
	assign supp_cp = {supp_hi, unit[9:0]};

	always_comb begin
		low_half_n   = low_half_q;
		half_valid_n = half_valid_q;
		held_high_n  = held_high_q;
		high_valid_n = high_valid_q;
		pre_v        = 1'b0;
		main_v       = 1'b0;
		main_cp      = {5'd0, unit};
		eos_v        = 1'b0;
		if (!half_valid_q) begin
			low_half_n   = in_byte;
			half_valid_n = 1'b1;
			if (end_of_stream) begin
				pre_v = high_valid_q;
				eos_v = 1'b1;
			end
		end else begin
			half_valid_n = 1'b0;
			if (high_valid_q) begin
				high_valid_n = 1'b0;
				if (is_low) begin
					main_v  = 1'b1;
					main_cp = supp_cp;
				end else begin
					pre_v = 1'b1;
					if (is_high) begin
						high_valid_n = 1'b1;
						held_high_n  = unit[9:0];
					end else begin
						main_v = 1'b1;
					end
				end
			end else if (is_high) begin
				high_valid_n = 1'b1;
				held_high_n  = unit[9:0];
			end else if (is_low) begin
				main_v  = 1'b1;
				main_cp = u16u8_pkg::REPL_CP;
			end else begin
				main_v = 1'b1;
			end
			// held high surrogate flushed at end
			if (end_of_stream) begin
				eos_v = high_valid_n;
			end
		end
		if (end_of_stream) begin
			low_half_n   = 8'd0;
			half_valid_n = 1'b0;
			held_high_n  = 10'd0;
			high_valid_n = 1'b0;
		end
	end

	always_comb begin
		run.cp0 = u16u8_pkg::REPL_CP;
		run.cp1 = u16u8_pkg::REPL_CP;
		run.two = 1'b0;
		push    = 1'b0;
		if (pre_v) begin
			run.cp1 = main_v ? main_cp : u16u8_pkg::REPL_CP;
			run.two = main_v | eos_v;
			push    = accept;
		end else if (main_v) begin
			run.cp0 = main_cp;
			run.two = eos_v;
			push    = accept;
		end else begin
			push = accept & eos_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			big_endian_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_half_q   <= 8'd0;
			half_valid_q <= 1'b0;
			held_high_q  <= 10'd0;
			high_valid_q <= 1'b0;
		end else if (accept) begin
			low_half_q   <= low_half_n;
			half_valid_q <= half_valid_n;
			held_high_q  <= held_high_n;
			high_valid_q <= high_valid_n;
		end
	end

	assign stat.half_valid = half_valid_q;
	assign stat.high_valid = high_valid_q;

endmodule

[rtl/u16u8_queue.sv]
// u16u8_queue: small fifo of runs between the front and the back
// uses u16u8_pkg for the run type and status struct
module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u16u8_pkg::run_t      push_run,
	input  logic                 pop,
	output u16u8_pkg::run_t      head,
	output u16u8_pkg::q_stat_t   stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	u16u8_pkg::run_t   mem_q [DEPTH];
	u16u8_pkg::run_t   head_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  rd_next;
	logic [CNT_W-1:0]  cnt_q;

	assign rd_next    = pop ? ((rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1)
	                        : rd_ptr_q;
	assign head       = head_q;
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	// head register, bypassed when the new request lands at the head slot
	always_ff @(posedge clk) begin
		if (push && (wr_ptr_q == rd_next)) begin
			head_q <= push_run;
		end else begin
			head_q <= mem_q[rd_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_next;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/u16u8_back.sv]
// u16u8_back: turns the head run into utf-8 bytes, one byte per cycle unless stalled,
// into an output register; uses u16u8_pkg for the run type
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::run_t      head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last_of_run
);

	logic                        sel_q;
	logic [1:0]                  idx_q;
	logic                        out_valid_q;
	logic [7:0]                  out_byte_q;
	logic                        last_q;

	logic [u16u8_pkg::CP_W-1:0]  cur_cp;
	logic [1:0]                  len_m1;
	logic [7:0]                  enc;
	logic                        open;
	logic                        adv;
	logic                        byte_last;
	logic                        run_end;

	function automatic logic [1:0] cp_len_m1(input logic [u16u8_pkg::CP_W-1:0] cp);
		logic [1:0] n;
		if (cp[20:7] == '0) begin
			n = 2'd0;
		end else if (cp[20:11] == '0) begin
			n = 2'd1;
		end else if (cp[20:16] == '0) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	function automatic logic [7:0] enc_byte(input logic [u16u8_pkg::CP_W-1:0] cp,
	                                        input logic [1:0] n, input logic [1:0] k);
		logic [7:0] b;
		case ({n, k})
			4'b00_00: b = {1'b0, cp[6:0]};
			4'b01_00: b = {3'b110, cp[10:6]};
			4'b01_01: b = {2'b10, cp[5:0]};
			4'b10_00: b = {4'b1110, cp[15:12]};
			4'b10_01: b = {2'b10, cp[11:6]};
			4'b10_10: b = {2'b10, cp[5:0]};
			4'b11_00: b = {5'b11110, cp[20:18]};
			4'b11_01: b = {2'b10, cp[17:12]};
			4'b11_10: b = {2'b10, cp[11:6]};
			4'b11_11: b = {2'b10, cp[5:0]};
			default:  b = 8'd0;
		endcase
		return b;
	endfunction

	assign cur_cp    = sel_q ? head.cp1 : head.cp0;
	assign len_m1    = cp_len_m1(cur_cp);
	assign enc       = enc_byte(cur_cp, len_m1, idx_q);
	assign open      = !out_valid_q || !out_stall;
	assign adv       = head_valid && open;
	assign byte_last = (idx_q == len_m1);
	assign run_end   = byte_last && (sel_q || !head.two);
	assign pop       = adv && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (open) begin
				out_valid_q <= head_valid;
			end
			if (adv) begin
				idx_q <= byte_last ? 2'd0 : idx_q + 2'd1;
				if (byte_last) begin
					sel_q <= !run_end;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= enc;
			last_q     <= run_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

[rtl/utf16_to_utf8_transcoder_top.sv]
// utf16_to_utf8_transcoder_top: utf-16 byte stream in, utf-8 byte stream out
// the first result byte of a request is registered in the queue head and then in the back's output register
// throughput: one input byte per cycle into the front unless the queue is full, one utf-8 byte per
// cycle from the back unless stalled; a request holds the back for all its bytes, the run queue absorbs bursts
// reset: arst_n clears the endian register, pairing state, queue and output valid flag at once
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back
module utf16_to_utf8_transcoder_top #(
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic                    accept;
	logic                    push;
	logic                    pop;
	u16u8_pkg::run_t         push_run;
	u16u8_pkg::run_t         head;
	u16u8_pkg::q_stat_t      q_stat;
	u16u8_pkg::front_stat_t  f_stat;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	u16u8_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.accept        (accept),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.push          (push),
		.run           (push_run),
		.stat          (f_stat)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!q_stat.empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("run popped from empty queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("run pushed into full queue");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_stream) |=> !(f_stat.half_valid || f_stat.high_valid))
		else $error("pairing state not cleared after end of stream");

endmodule
